// ===== rtl/empirical_semivariogram_core_macros.svh =====
// Assertion macros for the semivariogram core checker.
// No dependencies; taken in by the checker with `include.
`ifndef EMPIRICAL_SEMIVARIOGRAM_CORE_MACROS_SVH
`define EMPIRICAL_SEMIVARIOGRAM_CORE_MACROS_SVH

// same-cycle implication under reset
`define ESV_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("esv check failed");

// next-cycle implication under reset
`define ESV_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("esv check failed");

`endif

// ===== rtl/esv_pkg.sv =====
// Shared constants, types and state codes for the semivariogram core.
// No dependencies.
`timescale 1ns / 1ps
package esv_pkg;
    localparam int MAX_OBS   = 1024;
    localparam int MAX_BINS  = 64;
    localparam int OBS_W     = $clog2(MAX_OBS);
    localparam int OBS_CNT_W = $clog2(MAX_OBS + 1);
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int COORD_W   = 24;
    localparam int VAL_W     = 20;
    localparam int SQ_W      = 2 * COORD_W + 1;
    localparam int DIST_W    = COORD_W + 1;
    localparam int BW_W      = 24;
    localparam int LAG_W     = 26;
    localparam int NB_W      = 7;
    localparam int PAIR_W    = 21;
    localparam int SUM_W     = 64;
    localparam int DVSQ_W    = 2 * VAL_W;
    localparam int SV_W      = 40;
    localparam int IDX_W     = 6;
    localparam int QUOT_W    = 7;
    localparam int DATA_W    = 72;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int ITEM_W    = 2 * COORD_W + VAL_W;
    localparam int PADDR_W   = 4;

    localparam logic [1:0] REG_BIN_WIDTH = 2'd0;
    localparam logic [1:0] REG_MAX_LAG   = 2'd1;
    localparam logic [1:0] REG_NUM_BINS  = 2'd2;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [VAL_W-1:0]   value;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } item_t;

    typedef struct packed {
        logic [BW_W-1:0]  bw;
        logic [LAG_W-1:0] max_lag;
        logic [BIN_W-1:0] nm1;
    } cfg_t;

    typedef struct packed {
        logic push;
        logic full;
    } qctl_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLR, ST_PRD, ST_DIFF, ST_MUL, ST_SUM, ST_LAG,
        ST_BRD, ST_BUPD, ST_ERD, ST_EDAT, ST_EDIV, ST_OUT
    } back_state_t;
endpackage

// ===== rtl/esv_front.sv =====
// Front end: configuration registers, input accept and load/compute sorting.
// Depends on esv_pkg.
`timescale 1ns / 1ps
module esv_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [esv_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [esv_pkg::DATA_W-1:0] s_tdata,
    input  logic                      s_tuser,
    input  esv_pkg::qctl_t            q_stat,
    output esv_pkg::qctl_t            q_ctl,
    output esv_pkg::item_t            q_item,
    output esv_pkg::cfg_t             cfg
);
    import esv_pkg::*;

    logic [BW_W-1:0]      bw_reg, bw_next;
    logic [LAG_W-1:0]     lag_reg, lag_next;
    logic [NB_W-1:0]      nb_reg, nb_next;
    logic [OBS_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 wr_en, accept, store_full;
    logic [NB_W-1:0]      n_clamp;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        bw_next  = bw_reg;
        lag_next = lag_reg;
        nb_next  = nb_reg;
        if (wr_en) begin
            case (paddr[3:2])
                REG_BIN_WIDTH: bw_next  = pwdata[BW_W-1:0];
                REG_MAX_LAG:   lag_next = pwdata[LAG_W-1:0];
                REG_NUM_BINS:  nb_next  = pwdata[NB_W-1:0];
                default: ;
            endcase
        end
        case (paddr[3:2])
            REG_BIN_WIDTH: prdata = {{(32-BW_W){1'b0}}, bw_reg};
            REG_MAX_LAG:   prdata = {{(32-LAG_W){1'b0}}, lag_reg};
            REG_NUM_BINS:  prdata = {{(32-NB_W){1'b0}}, nb_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (nb_reg == '0)
            n_clamp = NB_W'(1);
        else if (nb_reg > NB_W'(MAX_BINS))
            n_clamp = NB_W'(MAX_BINS);
        else
            n_clamp = nb_reg;
        cfg.bw      = (bw_reg == '0) ? BW_W'(1) : bw_reg;
        cfg.max_lag = lag_reg;
        cfg.nm1     = BIN_W'(n_clamp - NB_W'(1));
    end

    assign s_tready   = !q_stat.full;
    assign accept     = s_tvalid && s_tready;
    assign store_full = (cnt_reg == OBS_CNT_W'(MAX_OBS));

    always_comb begin
        q_item.cmd   = s_tuser;
        q_item.x     = s_tdata[COORD_W-1:0];
        q_item.y     = s_tdata[2*COORD_W-1:COORD_W];
        q_item.value = s_tdata[ITEM_W-1:2*COORD_W];
        q_ctl.push   = accept && (s_tuser == CMD_COMPUTE || !store_full);
        q_ctl.full   = store_full;
        cnt_next     = cnt_reg;
        if (accept) begin
            if (s_tuser == CMD_COMPUTE)
                cnt_next = '0;
            else if (!store_full)
                cnt_next = cnt_reg + OBS_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bw_reg  <= BW_W'(1);
            lag_reg <= {LAG_W{1'b1}};
            nb_reg  <= NB_W'(MAX_BINS);
            cnt_reg <= '0;
        end else begin
            bw_reg  <= bw_next;
            lag_reg <= lag_next;
            nb_reg  <= nb_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

// ===== rtl/esv_queue.sv =====
// Short item queue between front and back end.
// Depends on esv_pkg.
`timescale 1ns / 1ps
module esv_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  esv_pkg::qctl_t in_ctl,
    input  esv_pkg::item_t in_item,
    output esv_pkg::qctl_t stat,
    output logic           out_valid,
    input  logic           out_pop,
    output esv_pkg::item_t out_item
);
    import esv_pkg::*;

    item_t            buf_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wp_reg, wp_next, rp_reg, rp_next;
    logic [Q_AW:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign stat.full  = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign stat.push  = do_push;
    assign out_valid  = (cnt_reg != '0);
    assign out_item   = buf_reg[rp_reg];
    assign do_push    = in_ctl.push && !stat.full;
    assign do_pop     = out_pop && out_valid;

    always_comb begin
        wp_next  = do_push ? wp_reg + Q_AW'(1) : wp_reg;
        rp_next  = do_pop ? rp_reg + Q_AW'(1) : rp_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + (Q_AW+1)'(1);
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - (Q_AW+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push)
            buf_reg[wp_reg] <= in_item;
    end
endmodule

// ===== rtl/esv_lag.sv =====
// Lag unit: bit-serial integer square root, then short division by bin width.
// Depends on esv_pkg.
`timescale 1ns / 1ps
module esv_lag (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [esv_pkg::SQ_W-1:0]    sq,
    input  logic [esv_pkg::BW_W-1:0]    bw,
    output logic                        done,
    output logic [esv_pkg::DIST_W-1:0]  lag_dist,
    output logic [esv_pkg::IDX_W-1:0]   quot
);
    import esv_pkg::*;

    localparam int OP_W  = 2 * DIST_W;
    localparam int REM_W = DIST_W + 3;
    localparam int DSH_W = BW_W + QUOT_W - 1;
    localparam int STEP_W = $clog2(DIST_W);

    logic               busy_reg, phase_reg, done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [OP_W-1:0]    op_reg;
    logic [REM_W-1:0]   rem_reg, rem_t, trial;
    logic [DIST_W-1:0]  root_reg, rd_reg;
    logic [DSH_W-1:0]   dsh_reg, rd_ext;
    logic [QUOT_W-1:0]  q_reg;

    assign rem_t    = {rem_reg[REM_W-3:0], op_reg[OP_W-1:OP_W-2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign rd_ext   = DSH_W'(rd_reg);
    assign done     = done_reg;
    assign lag_dist = root_reg;
    assign quot     = q_reg[QUOT_W-1] ? {IDX_W{1'b1}} : IDX_W'(q_reg[QUOT_W-2:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && phase_reg && step_reg == STEP_W'(QUOT_W-1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg    <= OP_W'(sq);
            rem_reg   <= '0;
            root_reg  <= '0;
            step_reg  <= '0;
            phase_reg <= 1'b0;
            q_reg     <= '0;
            dsh_reg   <= DSH_W'(bw) << (QUOT_W - 1);
        end else if (busy_reg) begin
            if (!phase_reg) begin
                op_reg <= op_reg << 2;
                if (rem_t >= trial) begin
                    rem_reg  <= rem_t - trial;
                    root_reg <= {root_reg[DIST_W-2:0], 1'b1};
                    rd_reg   <= {root_reg[DIST_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_t;
                    root_reg <= {root_reg[DIST_W-2:0], 1'b0};
                    rd_reg   <= {root_reg[DIST_W-2:0], 1'b0};
                end
                if (step_reg == STEP_W'(DIST_W-1)) begin
                    phase_reg <= 1'b1;
                    step_reg  <= '0;
                end else begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end else begin
                if (rd_ext >= dsh_reg) begin
                    rd_reg <= DIST_W'(rd_ext - dsh_reg);
                    q_reg  <= {q_reg[QUOT_W-2:0], 1'b1};
                end else begin
                    q_reg  <= {q_reg[QUOT_W-2:0], 1'b0};
                end
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end
endmodule

// ===== rtl/esv_div.sv =====
// Restoring divider, one quotient bit per cycle, for the bin means.
// Depends on esv_pkg.
`timescale 1ns / 1ps
module esv_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [esv_pkg::SUM_W-1:0]   dividend,
    input  logic [esv_pkg::PAIR_W:0]    divisor,
    output logic                        done,
    output logic [esv_pkg::SUM_W-1:0]   quotient
);
    import esv_pkg::*;

    localparam int DV_W  = PAIR_W + 1;
    localparam int CNT_W = $clog2(SUM_W);

    logic              busy_reg, done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  dvd_reg;
    logic [DV_W-1:0]   dvs_reg, rem_reg;
    logic [DV_W:0]     rem_t;

    assign rem_t    = {rem_reg, dvd_reg[SUM_W-1]};
    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == {CNT_W{1'b1}}) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (rem_t >= {1'b0, dvs_reg}) begin
                rem_reg <= DV_W'(rem_t - {1'b0, dvs_reg});
                dvd_reg <= {dvd_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_t[DV_W-1:0];
                dvd_reg <= {dvd_reg[SUM_W-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== rtl/esv_back.sv =====
// Back end: observation store, pair walk, bin accumulation and result output.
// Depends on esv_pkg, esv_lag and esv_div.
`timescale 1ns / 1ps
module esv_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  esv_pkg::cfg_t              cfg,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  esv_pkg::item_t             q_item,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [esv_pkg::DATA_W-1:0] m_tdata,
    output logic                       m_tlast
);
    import esv_pkg::*;

    localparam int ENT_W = PAIR_W + SUM_W;

    back_state_t state_reg, state_next;

    logic [ITEM_W-1:0]    store_mem [MAX_OBS];
    logic [ENT_W-1:0]     bin_mem [MAX_BINS];
    logic [ITEM_W-1:0]    rd_i_reg, rd_j_reg;
    logic [ENT_W-1:0]     bin_rd_reg;

    logic [OBS_CNT_W-1:0] cnt_reg, cnt_next, i_reg, i_next, j_reg, j_next;
    logic [BIN_W-1:0]     k_reg, k_next, baddr_reg, baddr_next;
    logic [COORD_W-1:0]   dx_reg, dy_reg;
    logic [VAL_W-1:0]     dv_reg;
    logic [2*COORD_W-1:0] dx2_reg, dy2_reg;
    logic [DVSQ_W-1:0]    dv2_reg;
    logic [SV_W-1:0]      sv_reg, sv_next;

    logic                 st_we, bin_we, lag_start, lag_done, div_start, div_done;
    logic [ENT_W-1:0]     bin_wd;
    logic [BIN_W-1:0]     bin_wa;
    logic [DIST_W-1:0]    lag_dist;
    logic [IDX_W-1:0]     quot;
    logic [SUM_W-1:0]     div_q;
    logic [SQ_W-1:0]      sq;
    logic [PAIR_W-1:0]    rd_pairs;
    logic [SUM_W-1:0]     rd_sum;
    logic signed [COORD_W:0] ddx, ddy;
    logic signed [VAL_W:0]   ddv;
    logic                 pair_last, out_load;

    logic                 mv_reg, mv_next, ml_reg;
    logic [DATA_W-1:0]    md_reg;

    assign rd_pairs = bin_rd_reg[ENT_W-1:SUM_W];
    assign rd_sum   = bin_rd_reg[SUM_W-1:0];
    assign sq       = SQ_W'(dx2_reg) + SQ_W'(dy2_reg);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

    esv_lag u_lag (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (lag_start),
        .sq       (sq),
        .bw       (cfg.bw),
        .done     (lag_done),
        .lag_dist (lag_dist),
        .quot     (quot)
    );

    esv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rd_sum),
        .divisor  ({rd_pairs, 1'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (st_we)
            store_mem[cnt_reg[OBS_W-1:0]] <= {q_item.value, q_item.y, q_item.x};
        rd_i_reg <= store_mem[i_reg[OBS_W-1:0]];
        rd_j_reg <= store_mem[j_reg[OBS_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (bin_we)
            bin_mem[bin_wa] <= bin_wd;
        bin_rd_reg <= bin_mem[baddr_reg];
    end

    always_comb begin
        ddx = $signed({rd_i_reg[COORD_W-1], rd_i_reg[COORD_W-1:0]})
            - $signed({rd_j_reg[COORD_W-1], rd_j_reg[COORD_W-1:0]});
        ddy = $signed({rd_i_reg[2*COORD_W-1], rd_i_reg[2*COORD_W-1:COORD_W]})
            - $signed({rd_j_reg[2*COORD_W-1], rd_j_reg[2*COORD_W-1:COORD_W]});
        ddv = $signed({rd_i_reg[ITEM_W-1], rd_i_reg[ITEM_W-1:2*COORD_W]})
            - $signed({rd_j_reg[ITEM_W-1], rd_j_reg[ITEM_W-1:2*COORD_W]});
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIFF) begin
            dx_reg <= ddx[COORD_W] ? COORD_W'(-ddx) : ddx[COORD_W-1:0];
            dy_reg <= ddy[COORD_W] ? COORD_W'(-ddy) : ddy[COORD_W-1:0];
            dv_reg <= ddv[VAL_W] ? VAL_W'(-ddv) : ddv[VAL_W-1:0];
        end
        if (state_reg == ST_MUL) begin
            dx2_reg <= dx_reg * dx_reg;
            dy2_reg <= dy_reg * dy_reg;
            dv2_reg <= dv_reg * dv_reg;
        end
    end

    assign pair_last = (j_reg + OBS_CNT_W'(1) == cnt_reg);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        baddr_next = baddr_reg;
        sv_next    = sv_reg;
        q_pop      = 1'b0;
        st_we      = 1'b0;
        bin_we     = 1'b0;
        bin_wa     = baddr_reg;
        bin_wd     = '0;
        lag_start  = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                q_pop = q_valid;
                if (q_valid) begin
                    if (q_item.cmd == CMD_COMPUTE) begin
                        k_next     = '0;
                        state_next = ST_CLR;
                    end else begin
                        st_we    = 1'b1;
                        cnt_next = cnt_reg + OBS_CNT_W'(1);
                    end
                end
            end
            ST_CLR: begin
                bin_we = 1'b1;
                bin_wa = k_reg;
                k_next = k_reg + BIN_W'(1);
                if (k_reg == BIN_W'(MAX_BINS - 1)) begin
                    k_next     = '0;
                    baddr_next = '0;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = (cnt_reg == '0) ? ST_ERD : ST_PRD;
                end
            end
            ST_PRD:  state_next = ST_DIFF;
            ST_DIFF: state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM: begin
                lag_start  = 1'b1;
                state_next = ST_LAG;
            end
            ST_LAG: begin
                if (lag_done) begin
                    baddr_next = (quot >= IDX_W'(cfg.nm1)) ? cfg.nm1 : BIN_W'(quot);
                    state_next = ST_BRD;
                    if ({1'b0, lag_dist} > cfg.max_lag)
                        state_next = ST_BUPD;
                end
            end
            ST_BRD: state_next = ST_BUPD;
            ST_BUPD: begin
                if ({1'b0, lag_dist} <= cfg.max_lag && rd_pairs != {PAIR_W{1'b1}}) begin
                    bin_we = 1'b1;
                    bin_wd = {rd_pairs + PAIR_W'(1), rd_sum + SUM_W'(dv2_reg)};
                end
                state_next = ST_PRD;
                if (pair_last) begin
                    j_next = '0;
                    i_next = i_reg + OBS_CNT_W'(1);
                    if (i_reg + OBS_CNT_W'(1) == cnt_reg) begin
                        baddr_next = '0;
                        state_next = ST_ERD;
                    end
                end else begin
                    j_next = j_reg + OBS_CNT_W'(1);
                end
            end
            ST_ERD: state_next = ST_EDAT;
            ST_EDAT: begin
                if (k_reg == '0 || rd_pairs == '0) begin
                    sv_next    = '0;
                    state_next = ST_OUT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_EDIV;
                end
            end
            ST_EDIV: begin
                if (div_done) begin
                    sv_next    = div_q[SV_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!mv_reg || m_tready) begin
                    out_load = 1'b1;
                    if (k_reg == cfg.nm1) begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + BIN_W'(1);
                        baddr_next = k_reg + BIN_W'(1);
                        state_next = ST_ERD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mv_next = mv_reg;
        if (out_load)
            mv_next = 1'b1;
        else if (m_tready)
            mv_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        baddr_reg <= baddr_next;
        sv_reg    <= sv_next;
        if (out_load) begin
            md_reg <= {{(DATA_W-IDX_W-SV_W-PAIR_W){1'b0}}, rd_pairs, sv_reg,
                       IDX_W'(k_reg)};
            ml_reg <= (k_reg == cfg.nm1);
        end
    end
endmodule

// ===== rtl/empirical_semivariogram_core.sv =====
// Channel    Dir  Width  Content
// s_ stream  in   72/1   tdata: coord_x, coord_y, sample_value; tuser: cmd
// m_ stream  out  72     tdata: bin_index, semivariance, pair_count; tlast: last
// APB        in   32     bin_width @0x0, max_lag @0x4, num_bins @0x8
//
// Loads stream in back to back through a 4-deep queue. A compute first clears all 64
// bins, then walks every ordered pair through the 25-step square root and 7-step bin
// division in the lag unit (the bin read is skipped past max_lag), then each bin through
// a 64-step serial division, skipped for bin 0 or an empty bin. Reset is synchronous,
// active low, and empties the store. Input accept stalls only when the queue is full;
// a stalled output holds.
`timescale 1ns / 1ps
module empirical_semivariogram_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [esv_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [23:0] coord_x, [47:24] coord_y, [67:48] sample_value, [71:68] zero
    input  logic [esv_pkg::DATA_W-1:0]  s_tdata,
    // [0] cmd
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [5:0] bin_index, [45:6] semivariance, [66:46] pair_count, [71:67] zero
    output logic [esv_pkg::DATA_W-1:0]  m_tdata,
    output logic                        m_tlast
);
    import esv_pkg::*;

    qctl_t q_ctl, q_stat;
    item_t f_item, b_item;
    cfg_t  cfg;
    logic  b_valid, b_pop;

    esv_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .q_ctl    (q_ctl),
        .q_item   (f_item),
        .cfg      (cfg)
    );

    esv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (q_ctl),
        .in_item   (f_item),
        .stat      (q_stat),
        .out_valid (b_valid),
        .out_pop   (b_pop),
        .out_item  (b_item)
    );

    esv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (b_valid),
        .q_pop    (b_pop),
        .q_item   (b_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );
endmodule

// ===== rtl/esv_checker.sv =====
// Port-level checks on the result stream of the semivariogram core.
// Depends on empirical_semivariogram_core_macros.svh; bound to the top level.
`timescale 1ns / 1ps
`include "empirical_semivariogram_core_macros.svh"
module esv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast
);
    `ESV_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `ESV_ASSERT_NOW(a_pad, aclk, aresetn, m_tvalid, m_tdata[71:67] == 5'd0)
    `ESV_ASSERT_NOW(a_bin0, aclk, aresetn, m_tvalid && m_tdata[5:0] == 6'd0, m_tdata[45:6] == 40'd0)
    `ESV_ASSERT_NOW(a_empty, aclk, aresetn, m_tvalid && m_tdata[66:46] == 21'd0, m_tdata[45:6] == 40'd0)
endmodule

bind empirical_semivariogram_core esv_checker u_esv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== bench/esv_checker.sv =====
// Checker for the semivariogram core: follows register writes and accepted requests,
// predicts the per-bin results and compares each accepted result with the oldest one.
// Depends on esv_pkg.
`timescale 1ns / 1ps
module esv_scoreboard (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [esv_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    // [23:0] coord_x, [47:24] coord_y, [67:48] sample_value, [71:68] zero
    input  logic [esv_pkg::DATA_W-1:0]  s_tdata,
    // [0] cmd
    input  logic                        s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    // [5:0] bin_index, [45:6] semivariance, [66:46] pair_count, [71:67] zero
    input  logic [esv_pkg::DATA_W-1:0]  m_tdata,
    input  logic                        m_tlast,
    output int                          fail_count,
    output int                          pending
);
    import esv_pkg::*;

    localparam int unsigned PAIR_CAP = 2097151;

    typedef struct {
        logic [IDX_W-1:0]  bin_index;
        logic [SV_W-1:0]   semivariance;
        logic [PAIR_W-1:0] pair_count;
        logic              last;
    } bin_result_t;

    bin_result_t      bin_results_q[$];
    logic [BW_W-1:0]  bin_width_r;
    logic [LAG_W-1:0] max_lag_r;
    logic [NB_W-1:0]  num_bins_r;
    int               site_x[MAX_OBS];
    int               site_y[MAX_OBS];
    int               site_v[MAX_OBS];
    int               site_count;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned abs_gap(int a, int b);
        longint d;
        d = longint'(a) - longint'(b);
        return (d < 0) ? longint'(-d) : d;
    endfunction

    task automatic predict_variogram();
        longint unsigned sums[MAX_BINS];
        int unsigned     pairs[MAX_BINS];
        longint unsigned dx, dy, pair_dist, bin, dv, bw;
        int unsigned     nb;
        bin_result_t     r;
        nb = num_bins_r;
        if (nb < 1) nb = 1;
        if (nb > MAX_BINS) nb = MAX_BINS;
        bw = (bin_width_r != 0) ? bin_width_r : 1;
        for (int k = 0; k < MAX_BINS; k++) begin
            sums[k] = 0;
            pairs[k] = 0;
        end
        for (int i = 0; i < site_count; i++) begin
            for (int j = 0; j < site_count; j++) begin
                dx = abs_gap(site_x[i], site_x[j]);
                dy = abs_gap(site_y[i], site_y[j]);
                pair_dist = int_sqrt(dx * dx + dy * dy);
                if (pair_dist <= max_lag_r) begin
                    bin = pair_dist / bw;
                    if (bin > nb - 1) bin = nb - 1;
                    if (pairs[bin] < PAIR_CAP) begin
                        dv = abs_gap(site_v[i], site_v[j]);
                        sums[bin] += dv * dv;
                        pairs[bin]++;
                    end
                end
            end
        end
        for (int k = 0; k < nb; k++) begin
            r.bin_index = IDX_W'(k);
            r.semivariance = SV_W'((k != 0 && pairs[k] != 0) ?
                                   sums[k] / (2 * pairs[k]) : 0);
            r.pair_count = PAIR_W'(pairs[k]);
            r.last = (k == nb - 1);
            bin_results_q.push_back(r);
        end
        site_count = 0;
    endtask

    assign pending = bin_results_q.size();

    always @(posedge aclk) begin
        bin_result_t e;
        if (!aresetn) begin
            bin_width_r = BW_W'(1);
            max_lag_r = 26'h3FFFFFF;
            num_bins_r = NB_W'(MAX_BINS);
            site_count = 0;
            bin_results_q.delete();
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_BIN_WIDTH: bin_width_r = pwdata[BW_W-1:0];
                    REG_MAX_LAG:   max_lag_r = pwdata[LAG_W-1:0];
                    REG_NUM_BINS:  num_bins_r = pwdata[NB_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (bin_results_q.size() == 0) begin
                    $error("result with nothing expected: tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    e = bin_results_q.pop_front();
                    if (m_tdata[5:0] !== e.bin_index) begin
                        $error("bin_index: expected %0d, got %0d", e.bin_index, m_tdata[5:0]);
                        fail_count++;
                    end
                    if (m_tdata[45:6] !== e.semivariance) begin
                        $error("semivariance: expected %0d, got %0d",
                               e.semivariance, m_tdata[45:6]);
                        fail_count++;
                    end
                    if (m_tdata[66:46] !== e.pair_count) begin
                        $error("pair_count: expected %0d, got %0d",
                               e.pair_count, m_tdata[66:46]);
                        fail_count++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last: expected %0d, got %0d", e.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_COMPUTE) begin
                    predict_variogram();
                end else if (site_count < MAX_OBS) begin
                    site_x[site_count] = $signed(s_tdata[23:0]);
                    site_y[site_count] = $signed(s_tdata[47:24]);
                    site_v[site_count] = $signed(s_tdata[67:48]);
                    site_count++;
                end
            end
        end
    end
endmodule

// ===== bench/tb_top.sv =====
// Top of the semivariogram core testbench: clock, reset, register writes and
// request stimulus under several idle patterns; esv_scoreboard does the comparison.
// Depends on esv_pkg, esv_scoreboard and empirical_semivariogram_core.
`timescale 1ns / 1ps
module tb_top;
    import esv_pkg::*;

    localparam int WATCHDOG = 200000;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                psel, penable, pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_tvalid, s_tready, s_tuser;
    logic [DATA_W-1:0]   s_tdata;
    logic                m_tvalid, m_tready, m_tlast;
    logic [DATA_W-1:0]   m_tdata;
    int                  fail_count, pending;
    int                  idle_pct, stall_pct, sent, quiet;

    always #5 aclk = ~aclk;

    empirical_semivariogram_core dut (.*);

    esv_scoreboard u_scoreboard (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast,
        .fail_count, .pending
    );

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_request(logic cmd, logic [23:0] x, logic [23:0] y, logic [19:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'b0, v, y, x};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [PADDR_W-1:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_config();
        logic [31:0] bw, lag, nb;
        case ($urandom_range(3))
            0: bw = 1;
            1: bw = $urandom_range(1, 2000);
            2: bw = 32'h00FFFFFF;
            default: bw = $urandom;
        endcase
        case ($urandom_range(3))
            0: lag = 32'h03FFFFFF;
            1: lag = $urandom_range(0, 5000);
            2: lag = 0;
            default: lag = $urandom;
        endcase
        case ($urandom_range(5))
            0: nb = 1;
            1: nb = 64;
            2: nb = 0;
            3: nb = $urandom_range(65, 127);
            default: nb = $urandom_range(1, 64);
        endcase
        write_reg({REG_BIN_WIDTH, 2'b00}, bw);
        write_reg({REG_MAX_LAG, 2'b00}, lag);
        write_reg({REG_NUM_BINS, 2'b00}, nb);
        if ($urandom_range(3) == 0) write_reg(4'hC, $urandom);
    endtask

    task automatic random_batch();
        int n;
        bit near;
        n = $urandom_range(0, 10);
        near = $urandom_range(3) != 0;
        repeat (n) begin
            if (near)
                send_request(CMD_LOAD, 24'($urandom_range(0, 4000) - 2000),
                             24'($urandom_range(0, 4000) - 2000), 20'($urandom));
            else
                send_request(CMD_LOAD, 24'($urandom), 24'($urandom), 20'($urandom));
        end
        send_request(CMD_COMPUTE, 24'($urandom), 24'($urandom), 20'($urandom));
    endtask

    initial begin
        int batches;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tuser = CMD_LOAD;
        s_tdata = '0;
        m_tready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        sent = 0;
        quiet = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty store, then field extremes with reset registers
        send_request(CMD_COMPUTE, '0, '0, '0);
        send_request(CMD_LOAD, 24'h800000, 24'h800000, 20'h80000);
        send_request(CMD_LOAD, 24'h7FFFFF, 24'h7FFFFF, 20'h7FFFF);
        send_request(CMD_LOAD, 24'h000000, 24'h000000, 20'h00000);
        send_request(CMD_LOAD, 24'h7FFFFF, 24'h800000, 20'h00001);
        send_request(CMD_COMPUTE, 24'hFFFFFF, 24'hFFFFFF, 20'hFFFFF);
        drain_results();
        // zero bin width and zero bin count
        write_reg({REG_BIN_WIDTH, 2'b00}, 0);
        write_reg({REG_NUM_BINS, 2'b00}, 0);
        send_request(CMD_LOAD, 24'd5, 24'd3, 20'd100);
        send_request(CMD_LOAD, 24'hFFFFFD, 24'd1, 20'hFFF00);
        send_request(CMD_COMPUTE, '0, '0, '0);
        drain_results();
        // oversized bin count, zero lag, widest bins, unknown register
        write_reg({REG_NUM_BINS, 2'b00}, 127);
        write_reg({REG_MAX_LAG, 2'b00}, 0);
        write_reg({REG_BIN_WIDTH, 2'b00}, 32'h00FFFFFF);
        write_reg(4'hC, 32'hFFFFFFFF);
        send_request(CMD_LOAD, 24'd7, 24'd7, 20'd9);
        send_request(CMD_LOAD, 24'd7, 24'd7, 20'hFFFF7);
        send_request(CMD_LOAD, 24'd8, 24'd7, 20'd1);
        send_request(CMD_COMPUTE, '0, '0, '0);
        drain_results();
        write_reg({REG_MAX_LAG, 2'b00}, 32'h03FFFFFF);
        write_reg({REG_BIN_WIDTH, 2'b00}, 200);
        write_reg({REG_NUM_BINS, 2'b00}, 16);

        sent = 0;
        batches = 0;
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 78 : (ph == 3) ? 27 : 0;
            stall_pct = (ph == 2) ? 78 : (ph == 3) ? 27 : 0;
            while (sent < 88 * (ph + 1)) begin
                random_batch();
                batches++;
                if (batches % 3 == 0) begin
                    drain_results();
                    random_config();
                end
            end
        end

        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
